@@ hw/rtl/stable_arrival_priority_queue_core_assert.svh @@
// Assertion macros for the stable arrival priority queue checker.
`ifndef STABLE_ARRIVAL_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define STABLE_ARRIVAL_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SAPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SAPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/sapq_pkg.sv @@
// Shared types, constants and control structs of the stable arrival priority queue.
package sapq_pkg;

    localparam int QUEUE_DEPTH_DEF = 128;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_SERVED   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SERVE  = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [53:0] buyer_id;
        logic [10:0] arrival_minute;
        logic [31:0] item_code;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [53:0] served_buyer;
        logic [10:0] served_arrival;
        logic [31:0] served_item;
        logic [7:0]  occupancy;
    } t_out;

    typedef struct packed {
        logic [53:0] buyer;
        logic [10:0] arrival;
        logic [31:0] item;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_DRAIN,
        S_SHIFT_INIT,
        S_SHIFT,
        S_SHIFT_DRAIN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic accept_insert;
        logic accept_serve;
        logic scan_issue;
        logic shift_init;
        logic shift_issue;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic scan_last;
        logic shift_none;
        logic shift_last;
    } t_sts;

endpackage

@@ hw/rtl/stable_arrival_priority_queue_core.sv @@
// Top level of the stable arrival priority queue: controller plus datapath.
//
// An item is taken when start is high and busy is low; its result appears on
// o_result for exactly one cycle, flagged by o_result_valid, in the cycle after
// the item finishes, and must be captured then since the receiver cannot stall.
// Insert, full drop and empty serve finish in the accept cycle, so busy never
// rises and the next item can follow at once. A serve on a non-empty queue
// keeps busy high while the entry RAM, one read port and one write port, is
// walked once to find the earliest arrival, one entry a cycle, then while the
// entries behind the winner are moved down one slot, one a cycle; the move is
// skipped when the winner is the newest entry. Entries are tracked by the fill
// count alone, so no clearing pass follows reset.
module stable_arrival_priority_queue_core #(
    parameter int QUEUE_DEPTH = sapq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  sapq_pkg::t_in   i_item,
    output sapq_pkg::t_out  o_result,
    output logic            o_result_valid
);

    sapq_pkg::t_cmd cmd;
    sapq_pkg::t_sts sts;

    sapq_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_op   (i_item.operation),
        .i_sts  (sts),
        .o_cmd  (cmd),
        .o_busy (busy)
    );

    sapq_datapath #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (i_item),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_result      (o_result),
        .o_result_valid(o_result_valid)
    );

endmodule

@@ hw/rtl/sapq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sapq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/sapq_ctrl.sv @@
// Controller state machine: sequences insert, scan for minimum, shift-down and finish.
module sapq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_op,
    input  sapq_pkg::t_sts  i_sts,
    output sapq_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    sapq_pkg::t_state r_state;
    sapq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sapq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sapq_pkg::S_IDLE: begin
                if (i_start && (i_op == sapq_pkg::OP_SERVE) && !i_sts.empty) begin
                    n_state = sapq_pkg::S_SCAN;
                end
            end
            sapq_pkg::S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = sapq_pkg::S_SCAN_DRAIN;
                end
            end
            sapq_pkg::S_SCAN_DRAIN: begin
                n_state = sapq_pkg::S_SHIFT_INIT;
            end
            sapq_pkg::S_SHIFT_INIT: begin
                n_state = i_sts.shift_none ? sapq_pkg::S_FINISH : sapq_pkg::S_SHIFT;
            end
            sapq_pkg::S_SHIFT: begin
                if (i_sts.shift_last) begin
                    n_state = sapq_pkg::S_SHIFT_DRAIN;
                end
            end
            sapq_pkg::S_SHIFT_DRAIN: begin
                n_state = sapq_pkg::S_FINISH;
            end
            sapq_pkg::S_FINISH: begin
                n_state = sapq_pkg::S_IDLE;
            end
            default: begin
                n_state = sapq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            sapq_pkg::S_IDLE: begin
                o_busy              = 1'b0;
                o_cmd.accept_insert = i_start && (i_op == sapq_pkg::OP_INSERT);
                o_cmd.accept_serve  = i_start && (i_op == sapq_pkg::OP_SERVE);
            end
            sapq_pkg::S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
            end
            sapq_pkg::S_SHIFT_INIT: begin
                o_cmd.shift_init = 1'b1;
            end
            sapq_pkg::S_SHIFT: begin
                o_cmd.shift_issue = 1'b1;
            end
            sapq_pkg::S_FINISH: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ hw/rtl/sapq_datapath.sv @@
// Datapath: entry RAM, count, address counter, minimum tracker and result register.
module sapq_datapath #(
    parameter int QUEUE_DEPTH = sapq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sapq_pkg::t_in   i_item,
    input  sapq_pkg::t_cmd  i_cmd,
    output sapq_pkg::t_sts  o_sts,
    output sapq_pkg::t_out  o_result,
    output logic            o_result_valid
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = $bits(sapq_pkg::t_entry);

    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_addr, n_addr;
    logic [AW-1:0]    r_didx, n_didx;
    logic             r_dv_scan, n_dv_scan;
    logic             r_dv_shift, n_dv_shift;
    logic             r_have_best, n_have_best;
    sapq_pkg::t_entry r_best, n_best;
    logic [AW-1:0]    r_best_idx, n_best_idx;
    sapq_pkg::t_out   r_res, n_res;
    logic             r_res_valid, n_res_valid;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    sapq_pkg::t_entry ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    sapq_pkg::t_entry ram_rdata;

    logic [CW-1:0]    count_inc;
    logic [CW-1:0]    count_dec;
    logic [CW-1:0]    best_next;
    logic             full;

    assign count_inc = r_count + CW'(1);
    assign count_dec = r_count - CW'(1);
    assign best_next = CW'(r_best_idx) + CW'(1);
    assign full      = (r_count == CW'(QUEUE_DEPTH));

    assign o_sts.empty      = (r_count == '0);
    assign o_sts.scan_last  = (CW'(r_addr) == count_dec);
    assign o_sts.shift_none = (best_next == r_count);
    assign o_sts.shift_last = (CW'(r_addr) == count_dec);

    sapq_ram #(
        .WIDTH(EW),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_count     = r_count;
        n_addr      = r_addr;
        n_didx      = r_didx;
        n_dv_scan   = i_cmd.scan_issue;
        n_dv_shift  = i_cmd.shift_issue;
        n_have_best = r_have_best;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_res       = r_res;
        n_res_valid = 1'b0;

        ram_we    = 1'b0;
        ram_waddr = r_didx - AW'(1);
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = r_addr;

        if (i_cmd.accept_insert) begin
            n_res_valid = 1'b1;
            n_res       = '0;
            if (full) begin
                n_res.status    = sapq_pkg::ST_FULL;
                n_res.occupancy = 8'(r_count);
            end else begin
                ram_we            = 1'b1;
                ram_waddr         = r_count[AW-1:0];
                ram_wdata.buyer   = i_item.buyer_id;
                ram_wdata.arrival = i_item.arrival_minute;
                ram_wdata.item    = i_item.item_code;
                n_count           = count_inc;
                n_res.status      = sapq_pkg::ST_INSERTED;
                n_res.occupancy   = 8'(count_inc);
            end
        end

        if (i_cmd.accept_serve) begin
            if (o_sts.empty) begin
                n_res_valid     = 1'b1;
                n_res           = '0;
                n_res.status    = sapq_pkg::ST_EMPTY;
                n_res.occupancy = 8'(r_count);
            end else begin
                n_addr      = '0;
                n_have_best = 1'b0;
            end
        end

        if (i_cmd.scan_issue || i_cmd.shift_issue) begin
            ram_re = 1'b1;
            n_didx = r_addr;
            n_addr = r_addr + AW'(1);
        end

        // strict less keeps the earliest inserted entry on equal keys
        if (r_dv_scan && (!r_have_best || (ram_rdata.arrival < r_best.arrival))) begin
            n_best      = ram_rdata;
            n_best_idx  = r_didx;
            n_have_best = 1'b1;
        end

        if (r_dv_shift) begin
            ram_we = 1'b1;
        end

        if (i_cmd.shift_init) begin
            n_addr = best_next[AW-1:0];
        end

        if (i_cmd.finish) begin
            n_count              = count_dec;
            n_res_valid          = 1'b1;
            n_res.status         = sapq_pkg::ST_SERVED;
            n_res.served_buyer   = r_best.buyer;
            n_res.served_arrival = r_best.arrival;
            n_res.served_item    = r_best.item;
            n_res.occupancy      = 8'(count_dec);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_dv_scan   <= 1'b0;
            r_dv_shift  <= 1'b0;
            r_have_best <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_dv_scan   <= n_dv_scan;
            r_dv_shift  <= n_dv_shift;
            r_have_best <= n_have_best;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_didx     <= n_didx;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_res      <= n_res;
    end

    assign o_result       = r_res;
    assign o_result_valid = r_res_valid;

endmodule

@@ hw/rtl/sapq_checker.sv @@
// Port-level checker for the stable arrival priority queue, bound to the top level.
`include "stable_arrival_priority_queue_core_assert.svh"

module sapq_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input sapq_pkg::t_in  i_item,
    input sapq_pkg::t_out o_result,
    input logic           o_result_valid
);

    `SAPQ_ASSERT_NEXT(a_insert_result, start && !busy && (i_item.operation == sapq_pkg::OP_INSERT), o_result_valid && !busy && ((o_result.status == sapq_pkg::ST_INSERTED) || (o_result.status == sapq_pkg::ST_FULL)), "insert item gave no insert or full result")
    `SAPQ_ASSERT_NOW(a_zero_fields, o_result_valid && (o_result.status != sapq_pkg::ST_SERVED), (o_result.served_buyer == '0) && (o_result.served_arrival == '0) && (o_result.served_item == '0), "served fields not zero on a non-serve result")
    `SAPQ_ASSERT_NOW(a_empty_occupancy, o_result_valid && (o_result.status == sapq_pkg::ST_EMPTY), o_result.occupancy == 8'd0, "empty result with nonzero occupancy")
    `SAPQ_ASSERT_NOW(a_busy_cause, $rose(busy), $past(start) && $past(i_item.operation == sapq_pkg::OP_SERVE), "busy rose without an accepted serve item")

endmodule

bind stable_arrival_priority_queue_core sapq_checker u_checker (.*);
